@@ rtl/shamd_pkg.sv @@
`default_nettype none

package shamd_pkg;

  // schedule store geometry
  localparam int SchedDepth = 16;
  localparam int SchedAw    = $clog2(SchedDepth);
  localparam int CntW       = 7;

  // sequencer counts inside one compression
  localparam logic [CntW-1:0] CNT_INIT        = CntW'(0);
  localparam logic [CntW-1:0] CNT_FIRST_ROUND = CntW'(3);
  localparam logic [CntW-1:0] CNT_SCHED_CALC  = CntW'(18);
  localparam logic [CntW-1:0] CNT_SCHED_END   = CntW'(65);
  localparam logic [CntW-1:0] CNT_LAST        = CntW'(66);
  localparam logic [CntW-1:0] CNT_SCHED_OFS   = CntW'(2);

  // padding
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_SLOT  = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [2:0] POS_LAST  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  // control from the sequencer to the round datapath
  typedef struct packed {
    logic       init;
    logic       step;
    logic       fold;
    logic       restore;
    logic [5:0] k_idx;
  } rnd_ctl_t;

  // word write from the byte packer into the schedule store
  typedef struct packed {
    logic               we;
    logic [SchedAw-1:0] addr;
    logic [31:0]        data;
  } ld_wr_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // schedule sigmas
  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // round sigmas
  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/shamd_ram.sv @@
`default_nettype none

// one write port, two registered read ports
module shamd_ram #(
  parameter int Depth = 16,
  parameter int Width = 32,
  localparam int Aw = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [Aw-1:0]    waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [Aw-1:0]    raddr_a,
  input  wire logic [Aw-1:0]    raddr_b,
  output logic      [Width-1:0] rdata_a,
  output logic      [Width-1:0] rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ rtl/shamd_sched.sv @@
`default_nettype none

// Message schedule around the 16-word store. In sequencer count c the
// word W[c-2] is formed; port A delivers W[t-15] and, registered in a_prev,
// W[t-16] (or W[t] in the first sixteen rounds); port B delivers W[t-7].
// The write slot never meets a read slot issued in the same cycle.
module shamd_sched
  import shamd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic [CntW-1:0] cnt,
  input  wire ld_wr_t          ld,
  output logic      [31:0]     w
);

  logic [31:0]        rd_a;
  logic [31:0]        rd_b;
  logic [31:0]        a_prev;
  logic [31:0]        w_prev;
  logic [31:0]        w_calc;
  logic [CntW-1:0]    t_cnt;
  logic               sched_we;
  logic               ram_we;
  logic [SchedAw-1:0] ram_waddr;
  logic [31:0]        ram_wdata;
  logic [SchedAw-1:0] raddr_a;
  logic [SchedAw-1:0] raddr_b;

  assign t_cnt   = cnt - CNT_SCHED_OFS;
  assign raddr_a = cnt[SchedAw-1:0];
  assign raddr_b = cnt[SchedAw-1:0] + SchedAw'(SchedDepth / 2);

  // expanded word; first sixteen come straight from the store
  always_comb begin
    if (cnt < CNT_SCHED_CALC) begin
      w_calc = a_prev;
    end else begin
      w_calc = a_prev + ssig0(rd_a) + rd_b + ssig1(w_prev);
    end
  end

  assign sched_we = (cnt >= CNT_SCHED_CALC) && (cnt <= CNT_SCHED_END);

  // byte packer and schedule never write in the same cycle
  always_comb begin
    if (ld.we) begin
      ram_we    = 1'b1;
      ram_waddr = ld.addr;
      ram_wdata = ld.data;
    end else begin
      ram_we    = sched_we;
      ram_waddr = t_cnt[SchedAw-1:0];
      ram_wdata = w_calc;
    end
  end

  shamd_ram #(
    .Depth (SchedDepth),
    .Width (32)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // w feeds the round next cycle; w_prev is W[t-2] for the next calc
  always_ff @(posedge clk) begin
    a_prev <= rd_a;
    w      <= w_calc;
    w_prev <= w;
  end

endmodule

`default_nettype wire

@@ rtl/shamd_round.sv @@
`default_nettype none

// Working variables a..h, one round per step, and the chaining value.
module shamd_round
  import shamd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rnd_ctl_t    ctl,
  input  wire logic [31:0] w,
  input  wire logic [2:0]  sel,
  output logic      [31:0] digest
);

  logic [31:0] r  [8];
  logic [31:0] cv [8];
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    ch  = (r[4] & r[5]) ^ (~r[4] & r[6]);
    maj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
    t1  = r[7] + bsig1(r[4]) + ch + K_TAB[ctl.k_idx] + w;
    t2  = bsig0(r[0]) + maj;
  end

  // round registers
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) begin
        r[i] <= cv[i];
      end
    end else if (ctl.step) begin
      r[0] <= t1 + t2;
      r[1] <= r[0];
      r[2] <= r[1];
      r[3] <= r[2];
      r[4] <= r[3] + t1;
      r[5] <= r[4];
      r[6] <= r[5];
      r[7] <= r[6];
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (rst || ctl.restore) begin
      for (int i = 0; i < 8; i++) begin
        cv[i] <= IV_TAB[i];
      end
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        cv[i] <= cv[i] + r[i];
      end
    end
  end

  assign digest = cv[sel];

endmodule

`default_nettype wire

@@ rtl/sha256_message_digest_top.sv @@
`default_nettype none
// Bytes: one word per cycle while idle; a completed 64-byte block then holds
// the input through the schedule/round run and the fold.
// End word: padding runs one byte per cycle to the block end, each block
// is compressed, then the eight digest words go out one per accepted cycle.
// Reset (synchronous, rst high): chaining value to the initial hash, length
// and fill cleared; the schedule store keeps its contents and needs no clear.

module sha256_message_digest_top
  import shamd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // byte_present
  input  wire logic        s_tlast,   // end_of_message
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_position
  output logic             m_tlast    // last_word
);

  state_t          state;
  state_t          state_next;
  logic [CntW-1:0] cnt;
  logic [5:0]      fill;
  logic [63:0]     len_bits;
  logic [31:0]     pack;
  logic            padding;
  logic            pad_first;
  logic            len_ok;
  logic [2:0]      out_idx;

  logic            in_acc;
  logic            out_acc;
  logic            put_en;
  logic [7:0]      put_val;
  logic [7:0]      pad_val;
  logic [7:0]      len_byte;
  logic [31:0]     pack_merged;
  ld_wr_t          ld;
  rnd_ctl_t        ctl;
  logic [31:0]     w;
  logic [31:0]     digest;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // byte source: message bytes while idle, pad bytes while padding
  assign len_byte = len_bits[{~fill[2:0], 3'b000} +: 8];

  always_comb begin
    if (pad_first) begin
      pad_val = PAD_BYTE;
    end else if (len_ok && (fill >= LEN_SLOT)) begin
      pad_val = len_byte;
    end else begin
      pad_val = '0;
    end
  end

  assign put_en  = (in_acc && s_tuser) || (state == ST_PAD);
  assign put_val = (state == ST_PAD) ? pad_val : s_tdata;

  // big-endian packing into schedule words
  always_comb begin
    if (fill[1:0] == 2'b00) begin
      pack_merged = {put_val, 24'b0};
    end else begin
      pack_merged = pack | (32'(put_val) << {~fill[1:0], 3'b000});
    end
  end

  assign ld.we   = put_en && (fill[1:0] == 2'b11);
  assign ld.addr = fill[5:2];
  assign ld.data = pack_merged;

  // round control
  assign ctl.init    = (state == ST_RUN) && (cnt == CNT_INIT);
  assign ctl.step    = (state == ST_RUN) && (cnt >= CNT_FIRST_ROUND);
  assign ctl.fold    = (state == ST_FOLD);
  assign ctl.restore = out_acc && (out_idx == POS_LAST);
  assign ctl.k_idx   = 6'(cnt - CNT_FIRST_ROUND);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_tuser && (fill == FILL_LAST)) begin
            state_next = ST_RUN;
          end else if (s_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_RUN: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!padding) begin
          state_next = ST_IDLE;
        end else if (pad_first || !len_ok) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_PAD: begin
        if (fill == FILL_LAST) begin
          state_next = ST_RUN;
        end
      end
      ST_OUT: begin
        if (out_acc && (out_idx == POS_LAST)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer and message bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      fill      <= '0;
      len_bits  <= '0;
      padding   <= 1'b0;
      pad_first <= 1'b0;
      len_ok    <= 1'b0;
      out_idx   <= '0;
    end else begin
      if ((state == ST_RUN) && (cnt != CNT_LAST)) begin
        cnt <= cnt + CntW'(1);
      end else begin
        cnt <= '0;
      end
      if (put_en) begin
        fill <= fill + 6'd1;
      end
      if (in_acc && s_tuser) begin
        len_bits <= len_bits + 64'd8;
      end
      if (in_acc && s_tlast) begin
        padding   <= 1'b1;
        pad_first <= 1'b1;
        len_ok    <= 1'b0;
      end
      // length goes in this block once the pad byte lands below the length slot
      if (state == ST_PAD) begin
        pad_first <= 1'b0;
        if (pad_first && (fill < LEN_SLOT)) begin
          len_ok <= 1'b1;
        end
      end
      if ((state == ST_FOLD) && padding && !pad_first && !len_ok) begin
        len_ok <= 1'b1;
      end
      if (out_acc) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == POS_LAST) begin
          padding  <= 1'b0;
          len_bits <= '0;
        end
      end
    end
  end

  // partial word
  always_ff @(posedge clk) begin
    if (put_en) begin
      pack <= pack_merged;
    end
  end

  shamd_sched u_sched (
    .clk (clk),
    .cnt (cnt),
    .ld  (ld),
    .w   (w)
  );

  shamd_round u_round (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .w      (w),
    .sel    (out_idx),
    .digest (digest)
  );

  // ports
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {5'b0, out_idx, digest};
  assign m_tlast  = (out_idx == POS_LAST);

endmodule

`default_nettype wire

@@ rtl/shamd_checker.sv @@
`default_nettype none

module shamd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tlast
);

  // stalled digest word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("digest word changed while stalled");

  // last flag marks position seven
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
    else $error("last flag out of step with word position");

  // no input taken while the digest is being emitted
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready during digest output");

  // words follow in order without a gap
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)))
    else $error("digest word sequence broken");

  // after the last word the block is ready for a new message
  a_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("block not idle after digest");

endmodule

bind sha256_message_digest_top shamd_checker u_shamd_checker (.*);

`default_nettype wire

@@ bench/tb_sha256_message_digest_top.sv @@
`timescale 1ns / 100ps

module tb_sha256_message_digest_top;

  // run shape
  localparam int ITEM_TARGET = 220;
  localparam int SINK_HOLD   = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 250;
  localparam int N_DIRECTED  = 20;
  localparam int N_BOUNDARY  = 3;

  // padding layout
  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LENGTH_SLOT = 6'd56;
  localparam logic [2:0] LAST_POS    = 3'd7;

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_word_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         eom;
    logic         typed;
    logic [255:0] digest;
  } stim_row_t;

  // directed words: bare end, byte with end, ignored words, walking ones
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    {8'h5a, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    {8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    {8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
    {8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},
    {8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
    {8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h7f, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'hff, 1'b0, 1'b1, 1'b0, 256'h0},
    {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    {8'h01, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h02, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h04, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h08, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h10, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h20, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'h40, 1'b1, 1'b0, 1'b0, 256'h0},
    {8'hfe, 1'b1, 1'b1, 1'b0, 256'h0}
  };

  // message lengths around the padding boundaries
  localparam int BOUNDARY_LENS [N_BOUNDARY] = '{55, 56, 64};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = 1'b0;    // byte_present
  logic        s_tlast = 1'b0;    // end_of_message
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [31:0] digest_word, [34:32] word_position
  logic        m_tlast;           // last_word

  sha256_message_digest_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hash state of the predictor
  logic [31:0] chain_h [8];
  logic [31:0] blk_w [16];
  logic [63:0] msg_bits;
  logic [5:0]  blk_fill;

  digest_word_t digest_q [$];

  int errors        = 0;
  int items_sent    = 0;
  int msgs_hashed   = 0;
  int words_checked = 0;
  int spill_count   = 0;
  int longest_msg   = 0;
  int idle_cycles   = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // 64 rounds over the held block, folded into the chaining value
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int t;
    for (t = 0; t < 16; t++) w[t] = blk_w[t];
    for (t = 16; t < 64; t++) begin
      s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (t = 0; t < 64; t++) begin
      t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[t] + w[t];
      t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  // big-endian byte packing into the block
  task automatic put_byte(input logic [7:0] v);
    logic [3:0] idx;
    idx = blk_fill[5:2];
    if (blk_fill[1:0] == 2'd0) blk_w[idx] = 32'h0;
    blk_w[idx][(3 - blk_fill[1:0]) * 8 +: 8] = v;
    blk_fill = blk_fill + 6'd1;
  endtask

  task automatic restart_hash();
    int i;
    for (i = 0; i < 8; i++) chain_h[i] = H_INIT[i];
    msg_bits = 64'd0;
    blk_fill = 6'd0;
  endtask

  // absorb one accepted word; on end of message pad and give the digest
  task automatic absorb_word(input logic [7:0] v, input logic present, input logic eom,
                             output logic done, output logic [255:0] digest);
    logic [63:0] len;
    int k;
    done   = 1'b0;
    digest = '0;
    if (present) begin
      put_byte(v);
      msg_bits = msg_bits + 64'd8;
      if (blk_fill == 6'd0) compress_block();
    end
    if (eom) begin
      len = msg_bits;
      if (int'(len >> 3) > longest_msg) longest_msg = int'(len >> 3);
      put_byte(PAD_MARK);
      if (blk_fill == 6'd0) begin
        compress_block();
        spill_count++;
      end else if (blk_fill > LENGTH_SLOT) begin
        while (blk_fill != 6'd0) put_byte(8'h00);
        compress_block();
        spill_count++;
      end
      while (blk_fill != LENGTH_SLOT) put_byte(8'h00);
      for (k = 7; k >= 0; k--) put_byte(len[k*8 +: 8]);
      compress_block();
      digest = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
      done = 1'b1;
      msgs_hashed++;
      restart_hash();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  // offer one word, wait for it to be taken, then queue its digest words
  task automatic send_item(input logic [7:0] v, input logic present, input logic eom,
                           input int gap, input logic use_typed,
                           input logic [255:0] typed_digest);
    logic         done;
    logic [255:0] digest;
    digest_word_t dw;
    int k;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom);
      s_tlast  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= present;
    s_tlast  <= eom;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    absorb_word(v, present, eom, done, digest);
    if (done) begin
      if (use_typed) digest = typed_digest;
      for (k = 0; k < 8; k++) begin
        dw.word = digest[255 - 32*k -: 32];
        dw.pos  = 3'(k);
        dw.last = (3'(k) == LAST_POS);
        digest_q = {digest_q, dw};
      end
    end
  endtask

  // random message: content, an end on the last byte or a bare end, some noise
  task automatic send_message(input int len);
    logic bare, calm;
    int i;
    bare = (len == 0) || ($urandom_range(0, 2) == 0);
    calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 6)
        send_item(8'($urandom), 1'b0, 1'b0, calm ? 0 : pick_gap(), 1'b0, '0);
      send_item(pick_byte(), 1'b1, (i == len - 1) && !bare, calm ? 0 : pick_gap(),
                1'b0, '0);
    end
    if (bare) send_item(8'($urandom), 1'b0, 1'b1, calm ? 0 : pick_gap(), 1'b0, '0);
  endtask

  // sender goes quiet until every queued digest word has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
  endtask

  // receiver: random back-pressure, calm stretches, one long hold-off
  initial begin : sink_ready
    int gap;
    int calm_left;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      if (calm_left > 0) begin
        calm_left--;
        gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        calm_left = $urandom_range(20, 80);
        gap = 0;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // compare each digest word with the oldest one queued
  always @(posedge clk) begin : word_check
    digest_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      words_checked++;
      if (digest_q.size() == 0) begin
        report_mismatch("word with none queued", {24'h0, m_tdata}, 64'h0);
      end else begin
        want = digest_q.pop_front();
        if (m_tdata[31:0] !== want.word)
          report_mismatch("digest_word", {32'h0, m_tdata[31:0]}, {32'h0, want.word});
        if (m_tdata[34:32] !== want.pos)
          report_mismatch("word_position", {61'h0, m_tdata[34:32]}, {61'h0, want.pos});
        if (m_tlast !== want.last)
          report_mismatch("last_word", {63'h0, m_tlast}, {63'h0, want.last});
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    int r;
    int len;
    bit mid_pause_done;
    mid_pause_done = 1'b0;
    for (k = 0; k < 16; k++) blk_w[k] = 32'h0;
    restart_hash();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (k = 0; k < N_DIRECTED; k++)
      send_item(DIRECTED_ROWS[k].data, DIRECTED_ROWS[k].present, DIRECTED_ROWS[k].eom,
                pick_gap(), DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].digest);
    drain_results();

    // one- and two-block padding, full block before the end
    for (k = 0; k < N_BOUNDARY; k++) send_message(BOUNDARY_LENS[k]);

    // receiver holds off while short messages keep coming
    hold_req = 1'b1;
    for (k = 0; k < 6; k++) send_message($urandom_range(0, 3));
    drain_results();

    // random messages, mostly short
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(0, 12);
      else if (r < 93) len = $urandom_range(13, 40);
      else len = $urandom_range(41, 130);
      if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
      send_message(len);
      if (!mid_pause_done && items_sent > 2 * ITEM_TARGET / 3) begin
        drain_results();
        mid_pause_done = 1'b1;
      end
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("hashed %0d messages from %0d words, longest %0d bytes, %0d spilt padding",
             msgs_hashed, items_sent, longest_msg, spill_count);
    $display("checked %0d digest words under random stalls and one long output hold",
             words_checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
